/* rtl/core/irc_tok_pkg.sv */
// Shared types and constants for the chat line tokenizer.
// Used by irc_tok_label and irc_message_tokenizer; depends on nothing.
package irc_tok_pkg;

   localparam int MAX_PARAM_INDEX = 15;
   localparam int CNT_W           = $clog2(MAX_PARAM_INDEX + 1);
   localparam int PARAM_NUM_MAX   = 15;

   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PREFIX = 3'd1,
      PH_PRE_SP = 3'd2,
      PH_CMD    = 3'd3,
      PH_CMD_SP = 3'd4,
      PH_PARAM  = 3'd5,
      PH_TRAIL  = 3'd6,
      PH_PAR_SP = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_SPACE  = 3'd0,
      KIND_PMARK  = 3'd1,
      KIND_PREFIX = 3'd2,
      KIND_CMD    = 3'd3,
      KIND_PARAM  = 3'd4,
      KIND_TMARK  = 3'd5,
      KIND_TRAIL  = 3'd6
   } kind_type;

   typedef struct packed {
      phase_type          phase;
      logic [CNT_W-1:0]   count;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   byte_kind;
      logic [3:0] param_number;
      logic       field_start;
      logic       line_end;
   } result_type;

endpackage

/* rtl/core/irc_tok_label.sv */
// Per-byte labeler: classifies one byte against the current phase and
// produces the result word and the next phase/parameter index. Uses irc_tok_pkg.
module irc_tok_label (
   input  irc_tok_pkg::state_type  state,
   input  logic [7:0]              in_byte,
   input  logic                    last_of_line,
   output irc_tok_pkg::result_type result,
   output irc_tok_pkg::state_type  state_next
);
   import irc_tok_pkg::*;

   logic             is_sp;
   logic             is_col;
   kind_type         kind;
   logic             start;
   phase_type        phase_nx;
   logic [CNT_W-1:0] count_nx;
   logic [CNT_W-1:0] count_inc;
   logic             is_lower;

   assign is_sp     = (in_byte == CH_SPACE);
   assign is_col    = (in_byte == CH_COLON);
   assign count_inc = (state.count < CNT_W'(MAX_PARAM_INDEX))
                      ? state.count + CNT_W'(1) : CNT_W'(MAX_PARAM_INDEX);
   assign is_lower  = (in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_Z);

   always_comb begin
      kind     = KIND_SPACE;
      start    = 1'b0;
      phase_nx = state.phase;
      count_nx = state.count;
      case (state.phase)
         PH_START: begin
            if (is_col) begin
               kind = KIND_PMARK; start = 1'b1; phase_nx = PH_PREFIX;
            end else if (!is_sp) begin
               kind = KIND_CMD; start = 1'b1; phase_nx = PH_CMD;
            end
         end
         PH_PREFIX: begin
            if (is_sp) phase_nx = PH_PRE_SP;
            else kind = KIND_PREFIX;
         end
         PH_PRE_SP: begin
            if (!is_sp) begin
               kind = KIND_CMD; start = 1'b1; phase_nx = PH_CMD;
            end
         end
         PH_CMD: begin
            if (is_sp) phase_nx = PH_CMD_SP;
            else kind = KIND_CMD;
         end
         PH_PARAM: begin
            if (is_sp) phase_nx = PH_PAR_SP;
            else kind = KIND_PARAM;
         end
         PH_TRAIL: begin
            kind = KIND_TRAIL;
         end
         PH_CMD_SP, PH_PAR_SP: begin
            if (!is_sp) begin
               // bump the index only when a previous parameter exists
               if (state.phase == PH_PAR_SP) count_nx = count_inc;
               start = 1'b1;
               if (is_col) begin
                  kind = KIND_TMARK; phase_nx = PH_TRAIL;
               end else begin
                  kind = KIND_PARAM; phase_nx = PH_PARAM;
               end
            end
         end
         default: begin
            phase_nx = PH_START;
         end
      endcase
   end

   always_comb begin
      result.out_byte     = (kind == KIND_CMD && is_lower) ? in_byte - CASE_OFFSET : in_byte;
      result.byte_kind    = kind;
      result.field_start  = start;
      result.line_end     = last_of_line;
      result.param_number = 4'd0;
      if (kind == KIND_PARAM || kind == KIND_TMARK || kind == KIND_TRAIL) begin
         result.param_number = (count_nx > CNT_W'(PARAM_NUM_MAX))
                               ? 4'(PARAM_NUM_MAX) : 4'(count_nx);
      end
      if (last_of_line) begin
         state_next.phase = PH_START;
         state_next.count = '0;
      end else begin
         state_next.phase = phase_nx;
         state_next.count = count_nx;
      end
   end

endmodule

/* rtl/core/irc_message_tokenizer.sv */
// Top level of the chat line tokenizer: input register, labeler, result register.
// Depends on irc_tok_pkg and irc_tok_label.
//
//   channel | ports                                           | direction
//   req     | req_valid, req_stall, req_in_byte, req_last_of_line | in word
//   rsp     | rsp_valid, rsp_stall, rsp_out_byte, rsp_byte_kind,  | out word
//           | rsp_param_number, rsp_field_start, rsp_line_end     |
//
// One word per cycle sustained while rsp is not stalled; a word accepted on req reaches
// rsp_valid through the input register, then the result register after the labeler.
// The phase and parameter index advance once per word, when a word moves from
// the input register into the result register.
// Synchronous reset clears both valid flags and returns to line start.
// A stall on rsp holds the result register; the input register keeps
// accepting until it is occupied too, and req_stall rises once it is.
module irc_message_tokenizer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_last_of_line,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output irc_tok_pkg::kind_type  rsp_byte_kind,
   output logic [3:0]             rsp_param_number,
   output logic                   rsp_field_start,
   output logic                   rsp_line_end
);
   import irc_tok_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;

   // line state
   state_type  state_ff, state_in;
   state_type  state_next;
   result_type result;

   logic       req_accept;
   logic       advance;

   // move a word forward when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   irc_tok_label u_label (
      .state        (state_ff),
      .in_byte      (in_byte_ff),
      .last_of_line (in_last_ff),
      .result       (result),
      .state_next   (state_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;

      // advance the line state only with a word that moves on
      state_in = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase <= PH_START;
         state_ff.count <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload: hold unless a new word lands
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_of_line;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_result_ff.out_byte;
   assign rsp_byte_kind    = out_result_ff.byte_kind;
   assign rsp_param_number = out_result_ff.param_number;
   assign rsp_field_start  = out_result_ff.field_start;
   assign rsp_line_end     = out_result_ff.line_end;

endmodule
